// ===== hw/rtl/atrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// atrlc_pkg: shared types and constants of the AT response line classifier
// Keyword texts, line codes and the window match function.
// ----------------------------------------------------------------------------
`default_nettype none

package atrlc_pkg;

    localparam int NKW = 7;
    localparam int WIN = 9;

    typedef logic [7:0]          t_byte;
    typedef logic [WIN-1:0][7:0] t_window;   // index 0 holds the newest byte
    typedef logic [NKW-1:0]      t_kw_set;

    typedef enum logic [3:0] {
        LC_OTHER     = 4'd0,
        LC_BLANK     = 4'd1,
        LC_SEND_OK   = 4'd2,
        LC_OK        = 4'd3,
        LC_SEND_FAIL = 4'd4,
        LC_ERROR     = 4'd5,
        LC_RX        = 4'd6,
        LC_CONNECT   = 4'd7,
        LC_CLOSED    = 4'd8
    } t_line_code;

    // Progress of the search for the first colon of a line
    typedef enum logic [1:0] {
        CP_NONE  = 2'd0,
        CP_COLON = 2'd1,
        CP_ONE   = 2'd2,
        CP_MORE  = 2'd3
    } t_colon;

    localparam t_byte NEWLINE = 8'h0a;
    localparam t_byte COLON   = 8'h3a;

    // Keywords right-aligned to the window, last character at index 0
    localparam t_window KW_TEXT [NKW] = '{
        {16'h0, "SEND OK"},
        {56'h0, "OK"},
        "SEND FAIL",
        {32'h0, "ERROR"},
        {40'h0, "+IPD"},
        {16'h0, "CONNECT"},
        {24'h0, "CLOSED"}
    };

    localparam logic [3:0] KW_LEN [NKW] = '{4'd7, 4'd2, 4'd9, 4'd5, 4'd4, 4'd7, 4'd6};

    localparam t_line_code KW_CODE [NKW] = '{
        LC_SEND_OK, LC_OK, LC_SEND_FAIL, LC_ERROR, LC_RX, LC_CONNECT, LC_CLOSED
    };

    // Flag every keyword that ends at the newest byte of the window
    function automatic t_kw_set window_hits(input t_window win);
        t_kw_set hits;
        hits = '1;
        for (int k = 0; k < NKW; k++) begin
            for (int i = 0; i < WIN; i++) begin
                if ((4'(i) < KW_LEN[k]) && (win[i] != KW_TEXT[k][i])) begin
                    hits[k] = 1'b0;
                end
            end
        end
        return hits;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/at_response_line_classifier.sv =====
// ----------------------------------------------------------------------------
// at_response_line_classifier: AT modem response line classifier
// Builds lines from received bytes, classifies each line by keyword on the
// newline and tracks the channel and the first data byte of rx lines.
// ----------------------------------------------------------------------------
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while i_ready takes each result; the line state
// register is updated in a single combinational pass per byte, and the output
// register is refilled in the same cycle that its result is taken.
// Reset: i_rst_n (synchronous, active low) clears the line state, the channel
// and the output valid flag.
`default_nettype none

module at_response_line_classifier
    import atrlc_pkg::*;
#(
    parameter int LINE_LIMIT = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_line_end,
    output logic [3:0]      o_line_code,
    output logic [7:0]      o_channel,
    output logic            o_payload_valid,
    output logic [7:0]      o_payload
);

    localparam int               POS_W   = $clog2(LINE_LIMIT);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LIMIT - 1);

    // Line state
    t_window          r_win,       n_win;
    logic [POS_W-1:0] r_pos,       n_pos;
    t_kw_set          r_found,     n_found;
    t_kw_set          r_pending,   n_pending;
    logic             r_zero,      n_zero;
    t_byte            r_first,     n_first;
    t_byte            r_sixth,     n_sixth;
    t_colon           r_colon,     n_colon;
    t_byte            r_follower,  n_follower;
    t_byte            r_channel,   n_channel;

    // Result register
    logic             r_out_valid;
    logic             r_line_end,  n_line_end;
    t_line_code       r_code,      n_code;
    logic             r_pvalid,    n_pvalid;
    t_byte            r_payload,   n_payload;

    logic             accept;
    logic             zero_now;
    t_window          shifted;

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign zero_now = r_zero || (i_rx_byte == 8'h00);
    assign shifted  = {r_win[WIN-2:0], i_rx_byte};

    // Handle one byte: close and classify a line, or append to it below the length limit
    always_comb begin
        n_win      = r_win;
        n_pos      = r_pos;
        n_found    = r_found;
        n_pending  = r_pending;
        n_zero     = r_zero;
        n_first    = r_first;
        n_sixth    = r_sixth;
        n_colon    = r_colon;
        n_follower = r_follower;
        n_channel  = r_channel;
        n_line_end = 1'b0;
        n_code     = LC_OTHER;
        n_pvalid   = 1'b0;
        n_payload  = 8'h00;

        if (i_rx_byte == NEWLINE) begin
            n_line_end = 1'b1;
            if (r_pos <= POS_W'(1)) begin
                n_code = LC_BLANK;
            end else begin
                // Lowest keyword index wins
                for (int k = NKW - 1; k >= 0; k--) begin
                    if (r_found[k]) begin
                        n_code = KW_CODE[k];
                    end
                end
                case (n_code)
                    LC_RX: begin
                        if (r_pos == POS_W'(5)) begin
                            n_channel = NEWLINE;
                        end else if (r_pos == POS_W'(6)) begin
                            n_channel = 8'h00;
                        end else begin
                            n_channel = r_sixth;
                        end
                        if (r_colon == CP_ONE) begin
                            n_pvalid = 1'b1;
                        end else if (r_colon == CP_MORE) begin
                            n_pvalid  = 1'b1;
                            n_payload = r_follower;
                        end
                    end
                    LC_CONNECT: n_channel = r_first;
                    LC_CLOSED:  n_channel = 8'h00;
                    default:    n_channel = r_channel;
                endcase
            end
            // Drop the line state
            n_win      = '0;
            n_pos      = '0;
            n_found    = '0;
            n_pending  = '0;
            n_zero     = 1'b0;
            n_first    = 8'h00;
            n_sixth    = 8'h00;
            n_colon    = CP_NONE;
            n_follower = 8'h00;
        end else if (r_pos < POS_MAX) begin
            n_found   = r_found | r_pending;
            n_pending = '0;
            if (r_pos == POS_W'(0)) begin
                n_first = i_rx_byte;
            end
            if (r_pos == POS_W'(5)) begin
                n_sixth = i_rx_byte;
            end
            case (r_colon)
                CP_ONE:   n_colon = CP_MORE;
                CP_COLON: begin
                    n_follower = i_rx_byte;
                    n_colon    = CP_ONE;
                end
                CP_NONE: begin
                    if (!r_zero && (i_rx_byte == COLON)) begin
                        n_colon = CP_COLON;
                    end
                end
                default:  n_colon = r_colon;
            endcase
            n_zero = zero_now;
            if (!zero_now) begin
                n_win     = shifted;
                n_pending = window_hits(shifted);
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Advance the line state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_pos      <= '0;
            r_found    <= '0;
            r_pending  <= '0;
            r_zero     <= 1'b0;
            r_first    <= 8'h00;
            r_sixth    <= 8'h00;
            r_colon    <= CP_NONE;
            r_follower <= 8'h00;
            r_channel  <= 8'h00;
        end else if (accept) begin
            r_win      <= n_win;
            r_pos      <= n_pos;
            r_found    <= n_found;
            r_pending  <= n_pending;
            r_zero     <= n_zero;
            r_first    <= n_first;
            r_sixth    <= n_sixth;
            r_colon    <= n_colon;
            r_follower <= n_follower;
            r_channel  <= n_channel;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_end <= n_line_end;
            r_code     <= n_code;
            r_pvalid   <= n_pvalid;
            r_payload  <= n_payload;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_line_end      = r_line_end;
    assign o_line_code     = r_code;
    assign o_channel       = r_channel;
    assign o_payload_valid = r_pvalid;
    assign o_payload       = r_payload;

    // Checks
    a_code_only_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_line_end) |-> (r_code == LC_OTHER))
        else $error("line code set on a byte that did not end a line");

    a_payload_only_on_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pvalid) |-> (r_code == LC_RX))
        else $error("payload delivered on a line that is not an rx line");

    a_position_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("line position beyond its limit");

    a_newline_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_rx_byte == NEWLINE)) |=> ((r_pos == '0) && (r_found == '0)))
        else $error("line state not cleared by newline");

endmodule

`default_nettype wire
